// ===== rtl/box_blur_3x3_rgb_macros.svh =====
// assertion macros shared by the box blur rtl
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

`ifndef SYNTH
`define BBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
`define BBR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define BBR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/bbr_pkg.sv =====
// shared constants, command type and divide-by-nine helper for the box blur
package bbr_pkg;

  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 768;

  localparam int COL_W  = $clog2(FRAME_WIDTH);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT + 2);
  localparam int WORD_W = 32;
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int SUM_W  = $clog2(9 * 255 + 1);

  localparam int DIV9_MUL    = 7282;
  localparam int DIV9_MUL_W  = 13;
  localparam int DIV9_SHIFT  = 16;
  localparam int PROD_W      = SUM_W + DIV9_MUL_W;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic             mem_op;
    logic             emit;
    logic             lft_en;
    logic             rgt_en;
    logic             top_ok;
    logic             bot_ok;
    logic             done;
  } bbr_cmd_t;

  // reciprocal multiply, exact for sums up to 9 * 255
  function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(DIV9_MUL);
    return p[DIV9_SHIFT +: CHAN_W];
  endfunction

endpackage

// ===== rtl/box_blur_3x3_rgb.sv =====
// streaming 3x3 rgb box blur: the item completing a neighbourhood passes the queue, s1, s2
// and output registers; the result lags its pixel by one row plus one pixel of input items.
// throughput one item per cycle while the output is not stalled, set by the single line
// ram access per item (one read, one write at different columns). reset clears positions,
// queue and pipeline valids only; line ram and window are not cleared, their stale rows
// are masked at the frame edges, so the first item can be taken in the cycle after reset.
module box_blur_3x3_rgb (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [bbr_pkg::WORD_W-1:0] in_pixel_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bbr_pkg::WORD_W-1:0] out_blurred_pixel,
  output logic                       out_frame_done
);
  import bbr_pkg::*;

  bbr_cmd_t push_cmd;
  bbr_cmd_t head_cmd;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  bbr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_pixel_word (in_pixel_word),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  bbr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  bbr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (head_cmd),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_blurred_pixel (out_blurred_pixel),
    .out_frame_done    (out_frame_done)
  );

endmodule

// ===== rtl/bbr_ram.sv =====
// generic single write port, single read port ram with registered read
module bbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bbr_front.sv =====
// front end: accepts items, tracks frame position and classifies each item
`include "box_blur_3x3_rgb_macros.svh"
module bbr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [bbr_pkg::WORD_W-1:0]     in_pixel_word,
  input  logic                           q_full,
  output logic                           q_push,
  output bbr_pkg::bbr_cmd_t              q_cmd
);
  import bbr_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept;
  logic             drain_phase;
  logic             at_edge;
  logic             at_last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    drain_phase = row_r >= ROW_W'(FRAME_HEIGHT);
    // first column of a row from the third on closes the row two above
    at_edge     = (col_r == '0) && (row_r >= ROW_W'(2));
    at_last     = at_edge && (row_r == ROW_W'(FRAME_HEIGHT + 1));

    q_cmd.col    = col_r;
    q_cmd.pix    = (in_req_type == REQ_PIXEL && !drain_phase) ?
                   in_pixel_word[WORD_W-1 -: PIX_W] : '0;
    q_cmd.mem_op = !at_last;
    q_cmd.emit   = at_edge || (col_r != '0 && row_r != '0);
    q_cmd.lft_en = at_edge || (col_r != COL_W'(1));
    q_cmd.rgt_en = !at_edge;
    q_cmd.top_ok = at_edge ? (row_r != ROW_W'(2)) : (row_r != ROW_W'(1));
    q_cmd.bot_ok = at_edge ? !at_last : (row_r < ROW_W'(FRAME_HEIGHT));
    q_cmd.done   = at_last;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (at_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == COL_W'(FRAME_WIDTH - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  `BBR_ASSERT_NXT(a_frame_wrap, clk, rst_n, accept && q_cmd.done, col_r == '0 && row_r == '0)
  `BBR_ASSERT_IMP(a_row_range, clk, rst_n, 1'b1, row_r <= ROW_W'(FRAME_HEIGHT + 1))

endmodule

// ===== rtl/bbr_queue.sv =====
// short command queue between the front end and the blur datapath
module bbr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bbr_pkg::bbr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output bbr_pkg::bbr_cmd_t head_cmd,
  output logic              empty
);
  import bbr_pkg::*;

  bbr_cmd_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full     = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/bbr_back.sv =====
// back end: line buffer, 3x3 window, channel sums and divide by nine
`include "box_blur_3x3_rgb_macros.svh"
module bbr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bbr_pkg::bbr_cmd_t         q_head,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bbr_pkg::WORD_W-1:0] out_blurred_pixel,
  output logic                      out_frame_done
);
  import bbr_pkg::*;

  logic                 adv;
  logic                 ram_wr_en;
  logic [2*PIX_W-1:0]   ram_rd_data;

  logic                 s1_v_r, s1_v_nxt;
  bbr_cmd_t             s1_cmd_r, s1_cmd_nxt;

  // window: column 0 is the newest, rows top, middle, bottom
  logic [PIX_W-1:0]     win_r [2][3];
  logic [PIX_W-1:0]     new_col [3];
  logic [PIX_W-1:0]     cells [3][3];
  logic [2:0]           col_en;
  logic [2:0]           row_en;

  logic                 s2_v_r, s2_v_nxt;
  logic [SUM_W-1:0]     s2_sum_r [3];
  logic [SUM_W-1:0]     s2_sum_nxt [3];
  logic                 s2_done_r, s2_done_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    out_pixel_r, out_pixel_nxt;
  logic                 out_done_r, out_done_nxt;

  // whole pipe moves when the output register is free or being taken
  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && !q_empty;
  assign ram_wr_en = adv && s1_v_r && s1_cmd_r.mem_op;

  // upper row in the high half, middle row in the low half
  bbr_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (FRAME_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (s1_cmd_r.col),
    .wr_data ({ram_rd_data[PIX_W-1:0], s1_cmd_r.pix}),
    .rd_en   (q_pop),
    .rd_addr (q_head.col),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    s1_v_nxt   = adv ? q_pop : s1_v_r;
    s1_cmd_nxt = q_pop ? q_head : s1_cmd_r;
  end

  always_comb begin
    new_col[0] = ram_rd_data[2*PIX_W-1:PIX_W];
    new_col[1] = ram_rd_data[PIX_W-1:0];
    new_col[2] = s1_cmd_r.pix;
    cells[0]   = win_r[1];
    cells[1]   = win_r[0];
    cells[2]   = new_col;
    col_en     = {s1_cmd_r.rgt_en, 1'b1, s1_cmd_r.lft_en};
    row_en     = {s1_cmd_r.bot_ok, 1'b1, s1_cmd_r.top_ok};
    for (int ch = 0; ch < 3; ch++) begin
      s2_sum_nxt[ch] = '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          if (col_en[k] && row_en[j]) begin
            s2_sum_nxt[ch] = s2_sum_nxt[ch] + SUM_W'(cells[k][j][ch*CHAN_W +: CHAN_W]);
          end
        end
      end
    end
    s2_v_nxt    = adv ? (s1_v_r && s1_cmd_r.emit) : s2_v_r;
    s2_done_nxt = s1_cmd_r.done;
  end

  always_comb begin
    out_valid_nxt = adv ? s2_v_r : out_valid_r;
    out_pixel_nxt = {div9(s2_sum_r[2]), div9(s2_sum_r[1]), div9(s2_sum_r[0]), ALPHA_OPAQUE};
    out_done_nxt  = s2_done_r;
  end

  always_ff @(posedge clk) begin
    s1_cmd_r <= s1_cmd_nxt;
    if (ram_wr_en) begin
      win_r[1] <= win_r[0];
      win_r[0] <= new_col;
    end
    if (adv && s1_v_r && s1_cmd_r.emit) begin
      s2_sum_r  <= s2_sum_nxt;
      s2_done_r <= s2_done_nxt;
    end
    if (adv && s2_v_r) begin
      out_pixel_r <= out_pixel_nxt;
      out_done_r  <= out_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_blurred_pixel = out_pixel_r;
  assign out_frame_done    = out_done_r;

  `BBR_ASSERT_NXT(a_pop_to_s1, clk, rst_n, q_pop, s1_v_r)
  `BBR_ASSERT_IMP(a_done_no_mem, clk, rst_n, s1_v_r && s1_cmd_r.done, s1_cmd_r.emit && !s1_cmd_r.mem_op)

endmodule
